### hdl/pes_pkg.sv
// Shared types and constants for the periodic event scheduler.
// No dependencies; imported by every module under hdl.
package pes_pkg;

    // Participant table size and index width
    localparam int MAX_NODES = 8;
    localparam int NODE_W    = $clog2(MAX_NODES);

    // Field widths fixed by the interface
    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 64;
    localparam int KIND_W   = 3;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NODE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BITCLK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD_OK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ADD_REF = 3'd4;

    // Bit clock period after reset
    localparam logic [PERIOD_W-1:0] BITCLK_RST_TICKS = 32'd16;

    // Input word
    typedef struct packed {
        logic                operation;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period_ticks;
        logic [TIME_W-1:0]   time_limit;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [SLOT_W-1:0] event_slot;
        logic [TIME_W-1:0] event_time;
    } t_out_word;

    // Table write request
    typedef struct packed {
        logic                en;
        logic                set_node;  // new participant: period and present flag too
        logic [NODE_W-1:0]   idx;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   due;
    } t_tbl_wr;

    // Table read data
    typedef struct packed {
        logic                present;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   due;
    } t_tbl_rd;

endpackage

### hdl/pes_table.sv
// Participant table: present flags, periods and next due times.
// Depends on pes_pkg. One write port, one read port at the scan index.
module pes_table
    import pes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_wr           i_wr,
    input  logic [NODE_W-1:0] i_rd_idx,
    output t_tbl_rd           o_rd
);

    logic [MAX_NODES-1:0] r_present;
    logic [PERIOD_W-1:0]  r_period [MAX_NODES];
    logic [TIME_W-1:0]    r_due    [MAX_NODES];

    // Present flags cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_wr.en && i_wr.set_node) begin
            r_present[i_wr.idx] <= 1'b1;
        end
    end

    // Payload entries, only read where present
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_due[i_wr.idx] <= i_wr.due;
            if (i_wr.set_node) begin
                r_period[i_wr.idx] <= i_wr.period;
            end
        end
    end

    // Read at scan index
    assign o_rd.present = r_present[i_rd_idx];
    assign o_rd.period  = r_period[i_rd_idx];
    assign o_rd.due     = r_due[i_rd_idx];

endmodule

### hdl/pes_alu.sv
// Shared 64-bit adder and unsigned less-than compare.
// Depends on pes_pkg. Purely combinational; operands chosen by the sequencer.
module pes_alu
    import pes_pkg::*;
(
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W-1:0] o_sum,
    output logic              o_lt
);

    // Times wrap modulo 2^64
    assign o_sum = i_a + i_b;
    assign o_lt  = (i_a < i_b);

endmodule

### hdl/periodic_event_scheduler.sv
// Periodic event scheduler, top level: sequencer, time registers, output register.
// Add: the result is loaded from the add state once the output register is free.
// Step: a scan of every table entry through the shared compare unit, then decide and,
// unless the limit comes first, advance. No new word is taken until back in idle.
// Synchronous active-low reset empties the table, sets the bit clock period to 16,
// its next due time to 16 and the current time to 0. Depends on pes_pkg.
module periodic_event_scheduler
    import pes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_ADV    = 3'd4;

    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MAX_NODES - 1);

    logic [2:0]          r_state, n_state;
    t_in_word            r_item;
    logic [PERIOD_W-1:0] r_tick_period;
    logic [TIME_W-1:0]   r_bit_due;
    logic [TIME_W-1:0]   r_now;
    logic [NODE_W-1:0]   r_idx;
    logic [TIME_W-1:0]   r_best_when;
    logic [PERIOD_W-1:0] r_best_period;
    logic                r_best_node;
    logic [NODE_W-1:0]   r_best_idx;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out;

    logic                in_fire, cfg_fire, can_load, add_refused, out_load;
    logic [TIME_W-1:0]   alu_a, alu_b, alu_sum;
    logic                alu_lt;
    t_tbl_wr             tbl_wr;
    t_tbl_rd             tbl_rd;

    // Handshakes
    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign add_refused = (r_item.period_ticks == '0)
                      || ({1'b0, r_item.slot} >= (SLOT_W + 1)'(MAX_NODES));

    // Output register load and hold
    assign out_load    = can_load && ((r_state == S_ADD) || (r_state == S_ADV)
                      || (r_state == S_DECIDE && alu_lt));
    assign n_out_valid = out_load ? 1'b1 : (r_out_valid && i_out_stall);

    // Operand selection for the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (r_state)
            S_IDLE: begin
                alu_a = r_now;
                alu_b = {{(TIME_W - PERIOD_W){1'b0}}, i_cfg_data};
            end
            S_ADD: begin
                alu_a = r_now;
                alu_b = {{(TIME_W - PERIOD_W){1'b0}}, r_item.period_ticks};
            end
            S_SCAN: begin
                alu_a = tbl_rd.due;
                alu_b = r_best_when;
            end
            S_DECIDE: begin
                alu_a = r_item.time_limit;
                alu_b = r_best_when;
            end
            S_ADV: begin
                alu_a = r_best_when;
                alu_b = {{(TIME_W - PERIOD_W){1'b0}}, r_best_period};
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    pes_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    // Table writes: new participant on add, deadline advance on a node step
    always_comb begin
        tbl_wr          = '0;
        tbl_wr.period   = r_item.period_ticks;
        tbl_wr.due      = alu_sum;
        tbl_wr.idx      = NODE_W'(r_item.slot);
        if (r_state == S_ADD && can_load && !add_refused) begin
            tbl_wr.en       = 1'b1;
            tbl_wr.set_node = 1'b1;
        end else if (r_state == S_ADV && can_load && r_best_node) begin
            tbl_wr.en  = 1'b1;
            tbl_wr.idx = r_best_idx;
        end
    end

    pes_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tbl_wr),
        .i_rd_idx (r_idx),
        .o_rd     (tbl_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in_word.operation == OP_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD: begin
                if (can_load) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (can_load) n_state = alu_lt ? S_IDLE : S_ADV;
            end
            S_ADV: begin
                if (can_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and time state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tick_period <= BITCLK_RST_TICKS;
            r_bit_due     <= {{(TIME_W - PERIOD_W){1'b0}}, BITCLK_RST_TICKS};
            r_now         <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (cfg_fire) begin
                        r_tick_period <= i_cfg_data;
                        r_bit_due     <= alu_sum;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                end
                S_DECIDE: begin
                    if (can_load && alu_lt) begin
                        r_now <= r_item.time_limit;
                    end
                end
                S_ADV: begin
                    if (can_load) begin
                        r_now <= r_best_when;
                        if (!r_best_node) r_bit_due <= alu_sum;
                    end
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    // Captured word and running best candidate
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item        <= i_in_word;
            r_best_when   <= r_bit_due;
            r_best_period <= r_tick_period;
            r_best_node   <= 1'b0;
            r_best_idx    <= '0;
        end else if (r_state == S_SCAN && tbl_rd.present && alu_lt) begin
            // strictly earlier only: bit clock and lower slots win ties
            r_best_when   <= tbl_rd.due;
            r_best_period <= tbl_rd.period;
            r_best_node   <= 1'b1;
            r_best_idx    <= r_idx;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (can_load) begin
            case (r_state)
                S_ADD: begin
                    r_out.event_time <= r_now;
                    if (add_refused) begin
                        r_out.event_kind <= KIND_ADD_REF;
                        r_out.event_slot <= '0;
                    end else begin
                        r_out.event_kind <= KIND_ADD_OK;
                        r_out.event_slot <= r_item.slot;
                    end
                end
                S_DECIDE: begin
                    if (alu_lt) begin
                        r_out.event_kind <= KIND_IDLE;
                        r_out.event_slot <= '0;
                        r_out.event_time <= r_item.time_limit;
                    end
                end
                S_ADV: begin
                    r_out.event_time <= r_best_when;
                    if (r_best_node) begin
                        r_out.event_kind <= KIND_NODE;
                        r_out.event_slot <= SLOT_W'(r_best_idx);
                    end else begin
                        r_out.event_kind <= KIND_BITCLK;
                        r_out.event_slot <= '0;
                    end
                end
                default: begin
                    r_out <= r_out;
                end
            endcase
        end
    end

endmodule

### tb/sv/pes_event_checker.sv
// Checker for the periodic event scheduler: watches the input, output and
// period-write channels, predicts every result word and compares field by field.
// Depends on pes_pkg.
module pes_event_checker
    import pes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in_word            i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out_word           i_out_word,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the participant table and the time registers
    logic                node_present [MAX_NODES];
    logic [PERIOD_W-1:0] node_period  [MAX_NODES];
    logic [TIME_W-1:0]   node_due     [MAX_NODES];
    logic [TIME_W-1:0]   bit_due;
    logic [TIME_W-1:0]   cur_time;
    logic [PERIOD_W-1:0] clk_ticks;
    int unsigned         used_slots;

    // Result words still owed by the block, oldest first
    t_out_word           expected_events [$];
    int                  mismatches = 0;
    int                  checked    = 0;

    assign o_mismatches = mismatches;
    assign o_checked    = checked;

    // One line per mismatch, each one counted
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Works out the result word of one accepted input word and updates the shadow
    function automatic t_out_word predict_event(input t_in_word w);
        t_out_word         r;
        logic [TIME_W-1:0] soonest;
        int                winner;
        r            = '0;
        r.event_time = cur_time;
        if (w.operation == OP_ADD) begin
            if (w.period_ticks == '0 || int'(w.slot) >= MAX_NODES) begin
                r.event_kind = KIND_ADD_REF;
            end else begin
                node_present[w.slot] = 1'b1;
                node_period[w.slot]  = w.period_ticks;
                node_due[w.slot]     = cur_time + w.period_ticks;
                if (int'(w.slot) >= used_slots) begin
                    used_slots = int'(w.slot) + 1;
                end
                r.event_kind = KIND_ADD_OK;
                r.event_slot = w.slot;
            end
        end else begin
            // bit clock first; a node only takes over when strictly earlier
            soonest = bit_due;
            winner  = -1;
            for (int i = 0; i < MAX_NODES; i++) begin
                if (i < used_slots && node_present[i] && node_due[i] < soonest) begin
                    soonest = node_due[i];
                    winner  = i;
                end
            end
            if (soonest > w.time_limit) begin
                cur_time     = w.time_limit;
                r.event_kind = KIND_IDLE;
                r.event_time = w.time_limit;
            end else begin
                cur_time     = soonest;
                r.event_time = soonest;
                if (winner < 0) begin
                    bit_due      = bit_due + clk_ticks;
                    r.event_kind = KIND_BITCLK;
                end else begin
                    node_due[winner] = node_due[winner] + node_period[winner];
                    r.event_kind     = KIND_NODE;
                    r.event_slot     = winner[SLOT_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // Results are taken before new words so a same-edge pair stays in order
    always @(posedge i_clk) begin : track
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                node_present[i] = 1'b0;
                node_period[i]  = '0;
                node_due[i]     = '0;
            end
            clk_ticks  = BITCLK_RST_TICKS;
            bit_due    = BITCLK_RST_TICKS;
            cur_time   = '0;
            used_slots = 0;
            expected_events.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf(
                        "result word with none expected: kind %0d slot %0d time %0h",
                        i_out_word.event_kind, i_out_word.event_slot,
                        i_out_word.event_time));
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_word.event_kind !== want.event_kind) begin
                        report_mismatch($sformatf("word %0d event_kind %0d, expected %0d",
                            checked, i_out_word.event_kind, want.event_kind));
                    end
                    if (i_out_word.event_slot !== want.event_slot) begin
                        report_mismatch($sformatf("word %0d event_slot %0d, expected %0d",
                            checked, i_out_word.event_slot, want.event_slot));
                    end
                    if (i_out_word.event_time !== want.event_time) begin
                        report_mismatch($sformatf("word %0d event_time %0h, expected %0h",
                            checked, i_out_word.event_time, want.event_time));
                    end
                    checked++;
                end
            end
            // period write re-arms the bit clock from the present time
            if (i_cfg_valid && i_cfg_ready) begin
                clk_ticks = i_cfg_data;
                bit_due   = cur_time + i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_events.push_back(predict_event(i_in_word));
            end
        end
        o_pending <= expected_events.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the periodic event scheduler testbench: clock, reset, stimulus, output
// stall and watchdog. Prediction and checking live in pes_event_checker.
// Depends on pes_pkg, periodic_event_scheduler and pes_event_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pes_pkg::*;

    // Longest legitimate silence is the output hold-off plus one step; keep a wide margin
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_WORDS    = 155;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    t_in_word            in_word;
    logic                out_valid;
    logic                out_stall;
    t_out_word           out_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data;

    int                  pending;
    int                  checked;
    int                  mismatches;

    // Stimulus bookkeeping
    logic [TIME_W-1:0]   horizon    = '0;
    bit                  quiet      = 1'b0;
    int                  hold_asked = 0;
    int                  hold_served = 0;
    int                  adds_sent  = 0;
    int                  steps_sent = 0;
    int                  period_writes = 0;

    periodic_event_scheduler uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    pes_event_checker event_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_mismatches (mismatches)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one word after a random gap and waits until it is taken
    task automatic offer_word(input t_in_word w);
        while (!quiet && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic add_node(input logic [SLOT_W-1:0] slot, input logic [PERIOD_W-1:0] ticks);
        t_in_word w;
        w              = '0;
        w.operation    = OP_ADD;
        w.slot         = slot;
        w.period_ticks = ticks;
        w.time_limit   = {$urandom, $urandom};  // ignored by an add
        offer_word(w);
        adds_sent++;
    endtask

    task automatic run_step(input logic [TIME_W-1:0] lim);
        t_in_word w;
        w              = '0;
        w.operation    = OP_STEP;
        w.slot         = SLOT_W'($urandom_range(7));  // ignored by a step
        w.period_ticks = $urandom;
        w.time_limit   = lim;
        offer_word(w);
        steps_sent++;
    endtask

    // Stops offering and waits until every owed result word has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Writes the bit clock period; only called with the block idle
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_writes++;
    endtask

    // Mostly steps creeping just past the running horizon, so events keep firing
    task automatic random_item();
        int unsigned       pick;
        int unsigned       r;
        logic [PERIOD_W-1:0] ticks;
        logic [TIME_W-1:0] lim;
        pick = $urandom_range(99);
        if (pick < 22) begin
            r = $urandom_range(99);
            if (r < 5) begin
                ticks = '0;                         // refused
            end else if (r < 8) begin
                ticks = '1;
            end else if (r < 15) begin
                ticks = $urandom;
            end else begin
                ticks = $urandom_range(48, 1);
            end
            add_node(SLOT_W'($urandom_range(7)), ticks);
        end else begin
            if (pick < 30) begin
                lim = {$urandom, $urandom};         // anywhere at all
            end else if (pick < 34) begin
                lim = horizon - $urandom_range(40); // behind the clock: idle, time moves back
            end else begin
                horizon = horizon + $urandom_range(24);
                lim     = horizon;
            end
            run_step(lim);
        end
    endtask

    // Output side: random stalls, plus a long hold-off on request
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_asked) begin
                hold_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    // Ends the run when no channel moves for too long
    initial begin : watchdog
        int silent;
        silent = 0;
        while (silent < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
                silent = 0;
            end else begin
                silent++;
            end
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, nothing due by time 0: idle
        run_step('0);
        add_node(3'd0, '0);                 // zero period is refused
        add_node(3'd0, 32'd5);
        add_node(3'd7, 32'd5);              // same deadline as slot 0, lower slot wins
        add_node(3'd3, 32'd16);             // same deadline as the bit clock, bit clock wins
        repeat (4) run_step(64'd100);
        run_step(64'd4);                    // limit behind the next event: idle at the limit
        add_node(3'd7, '1);                 // overwrite an occupied slot, longest period
        add_node(3'd2, 32'd1);
        repeat (4) run_step('1);
        settle();
        write_period('1);
        repeat (2) run_step('1);
        settle();
        write_period(32'd1);
        repeat (3) run_step('1);
        settle();
        // zero period: the bit clock keeps firing at one time
        write_period('0);
        repeat (3) run_step('1);

        // Random phases, each under its own bit clock period
        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: write_period(32'd1);
                1: write_period($urandom_range(40, 2));
                2: write_period('1);
                3: write_period($urandom_range(32'hFFFF_FFFF, 1));
                4: write_period($urandom_range(12, 3));
                default: write_period(BITCLK_RST_TICKS);
            endcase
            quiet = (p == 3);
            if (p == 1) begin
                hold_asked++;                   // receiver holds off while words keep coming
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 4 && k == PHASE_WORDS / 2) begin
                    settle();                   // sender waits for every result mid-phase
                end
                random_item();
            end
        end
        quiet = 1'b0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d add and %0d step words across %0d bit clock period writes;",
            adds_sent, steps_sent, period_writes);
        $display("%0d results compared, with a %0d-cycle output hold-off, a mid-phase drain %s",
            checked, HOLD_CYCLES, "and a stretch without idling.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### sim.f
hdl/pes_pkg.sv
hdl/pes_table.sv
hdl/pes_alu.sv
hdl/periodic_event_scheduler.sv
tb/sv/pes_event_checker.sv
tb/sv/testbench.sv
